@@ design/rgbh_pkg.sv @@
// shared types and constants of the rgb hue band threshold unit
// used by rgbh_divider, rgb_hue_band_threshold_unit and the testbench; no dependencies
package rgbh_pkg;

  // channel and arithmetic widths
  localparam int unsigned CH_W   = 8;
  localparam int unsigned NUM_W  = 14;  // 43 * 255 fits in 14 bits
  localparam int unsigned QUO_W  = 6;   // quotient never exceeds 43
  localparam int unsigned HUE_W  = 8;
  localparam int unsigned CMP_W  = 10;  // signed band compare, no wrap
  localparam int unsigned CFG_IDX_W = 2;

  // hue rule constants
  localparam logic [CH_W-1:0]  HUE_BASE_RED   = 8'd0;
  localparam logic [CH_W-1:0]  HUE_BASE_GREEN = 8'd85;
  localparam logic [CH_W-1:0]  HUE_BASE_BLUE  = 8'd171;
  localparam logic [QUO_W-1:0] HUE_SCALE      = 6'd43;

  // mask output codes
  localparam logic [CH_W-1:0] MASK_ON  = 8'd255;
  localparam logic [CH_W-1:0] MASK_OFF = 8'd0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VALUE_THRESHOLD = 2'd0,
    CFG_HUE_CENTER      = 2'd1,
    CFG_HUE_HALF_WIDTH  = 2'd2
  } cfg_idx_t;

  // sideband that travels with a pixel through the divider
  typedef struct packed {
    logic            live;  // bright enough and not grey
    logic            neg;   // hue offset is subtracted from base
    logic [HUE_W-1:0] base;
  } hue_tag_t;

endpackage

@@ design/rgbh_divider.sv @@
// pipelined restoring divider for the hue offset, two quotient bits per stage
// depends on rgbh_pkg for widths and the sideband type
module rgbh_divider
  import rgbh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_dividend,
  input  logic [CH_W-1:0]  in_divisor,
  input  hue_tag_t         in_tag,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quotient,
  output hue_tag_t         out_tag
);

  localparam int unsigned BPS    = 2;
  localparam int unsigned STAGES = QUO_W / BPS;

  // stage registers
  logic             vld_r [STAGES];
  logic [NUM_W-1:0] rem_r [STAGES];
  logic [QUO_W-1:0] quo_r [STAGES];
  logic [CH_W-1:0]  dvs_r [STAGES];
  hue_tag_t         tag_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic             vld_in;
    logic [NUM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [CH_W-1:0]  dvs_in;
    hue_tag_t         tag_in;
    logic [NUM_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    // stage input selection
    if (s == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = in_dividend;
      assign quo_in = '0;
      assign dvs_in = in_divisor;
      assign tag_in = in_tag;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign dvs_in = dvs_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    // two trial subtractions of the shifted divisor
    always_comb begin
      logic [NUM_W:0] trial;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int j = 0; j < BPS; j++) begin
        trial = {1'b0, rem_nxt}
              - ({{(NUM_W+1-CH_W){1'b0}}, dvs_in} << (QUO_W - 1 - s*BPS - j));
        if (!trial[NUM_W]) begin
          rem_nxt = trial[NUM_W-1:0];
        end
        quo_nxt = {quo_nxt[QUO_W-2:0], ~trial[NUM_W]};
      end
    end

    // valid bit with reset, payload without
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      quo_r[s] <= quo_nxt;
      dvs_r[s] <= dvs_in;
      tag_r[s] <= tag_in;
    end
  end

  assign out_valid    = vld_r[STAGES-1];
  assign out_quotient = quo_r[STAGES-1];
  assign out_tag      = tag_r[STAGES-1];

  // checks
  a_valid_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid, STAGES))
    else $error("divider produced a transaction that never entered");

  a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tag.live |-> out_quotient <= HUE_SCALE)
    else $error("hue offset quotient out of range");

  a_tag_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tag == $past(in_tag, STAGES))
    else $error("sideband lost alignment with its quotient");

endmodule

@@ design/rgb_hue_band_threshold_unit.sv @@
// top level of the rgb hue band threshold unit: pixel in, mask pixel out
// depends on rgbh_pkg and rgbh_divider
//
// Usage:
//   A pixel (in_red, in_green, in_blue) is taken at a clock edge where start
//   is high and busy is low. busy is high only while rst_n is asserted and in
//   the cycle after, so one pixel can be taken in every clock cycle.
//   Each pixel gives one mask pixel on out_mask_value (255 or 0), shown for
//   one cycle with out_valid high, once it has passed the stage chain below.
//   Throughput is one pixel per cycle; the stage chain is:
//   max/min and branch select, multiply by 43, a three stage divider that
//   resolves two quotient bits per stage, and the band compare.
//   The receiver cannot stall, so there is no back pressure anywhere.
//   Registers are written through cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high and an unknown index is ignored.
//   Write them only while no pixel is in flight.
//   Reset (synchronous, rst_n low) clears the configuration registers to 0
//   and drops every transaction in flight.
module rgb_hue_band_threshold_unit
  import rgbh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // pixel channel
  input  logic                 start,
  output logic                 busy,
  input  logic [CH_W-1:0]      in_red,
  input  logic [CH_W-1:0]      in_green,
  input  logic [CH_W-1:0]      in_blue,
  // mask channel
  output logic                 out_valid,
  output logic [CH_W-1:0]      out_mask_value,
  // register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CH_W-1:0]      cfg_data
);

  localparam int unsigned LAT = 6;

  logic                busy_r;
  logic [CH_W-1:0]     value_threshold_r;
  logic [CH_W-1:0]     hue_center_r;
  logic [CH_W-1:0]     hue_half_width_r;

  logic                accept;

  // busy only around reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_threshold_r <= '0;
      hue_center_r      <= '0;
      hue_half_width_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VALUE_THRESHOLD: value_threshold_r <= cfg_data;
        CFG_HUE_CENTER:      hue_center_r      <= cfg_data;
        CFG_HUE_HALF_WIDTH:  hue_half_width_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: max, min, branch and signed difference
  logic [CH_W-1:0] mx, mn, dif, mag;
  logic            neg;
  logic [HUE_W-1:0] base;
  logic            live;

  always_comb begin
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx)  mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn)  mn = in_blue;
    dif = mx - mn;
    if (mx == in_red) begin
      base = HUE_BASE_RED;
      neg  = in_green < in_blue;
      mag  = neg ? (in_blue - in_green) : (in_green - in_blue);
    end else if (mx == in_green) begin
      base = HUE_BASE_GREEN;
      neg  = in_blue < in_red;
      mag  = neg ? (in_red - in_blue) : (in_blue - in_red);
    end else begin
      base = HUE_BASE_BLUE;
      neg  = in_red < in_green;
      mag  = neg ? (in_green - in_red) : (in_red - in_green);
    end
    live = (mx != '0) && (mx >= value_threshold_r) && (dif != '0);
  end

  logic            s1_valid_r;
  logic [CH_W-1:0] s1_mag_r;
  logic [CH_W-1:0] s1_dif_r;
  hue_tag_t        s1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_mag_r <= mag;
    s1_dif_r <= dif;
    s1_tag_r <= '{live: live, neg: neg, base: base};
  end

  // stage 2: scale the difference by 43
  logic             s2_valid_r;
  logic [NUM_W-1:0] s2_num_r;
  logic [CH_W-1:0]  s2_dif_r;
  hue_tag_t         s2_tag_r;
  logic [NUM_W-1:0] num_nxt;

  assign num_nxt = NUM_W'({{(NUM_W-CH_W){1'b0}}, s1_mag_r}
                   * {{(NUM_W-QUO_W){1'b0}}, HUE_SCALE});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_num_r <= num_nxt;
    s2_dif_r <= s1_dif_r;
    s2_tag_r <= s1_tag_r;
  end

  // stages 3 to 5: hue offset division
  logic             div_valid;
  logic [QUO_W-1:0] div_quo;
  hue_tag_t         div_tag;

  rgbh_divider u_divider (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (s2_valid_r),
    .in_dividend  (s2_num_r),
    .in_divisor   (s2_dif_r),
    .in_tag       (s2_tag_r),
    .out_valid    (div_valid),
    .out_quotient (div_quo),
    .out_tag      (div_tag)
  );

  // stage 6: hue and band compare
  logic [HUE_W-1:0]        offs;
  logic [HUE_W-1:0]        hue;
  logic signed [CMP_W-1:0] hue_s, band_lo, band_hi;
  logic                    in_band;

  always_comb begin
    offs    = {{(HUE_W-QUO_W){1'b0}}, div_quo};
    hue     = div_tag.neg ? (div_tag.base - offs) : (div_tag.base + offs);
    hue_s   = $signed({{(CMP_W-HUE_W){1'b0}}, hue});
    band_lo = $signed({{(CMP_W-CH_W){1'b0}}, hue_center_r})
            - $signed({{(CMP_W-CH_W){1'b0}}, hue_half_width_r});
    band_hi = $signed({{(CMP_W-CH_W){1'b0}}, hue_center_r})
            + $signed({{(CMP_W-CH_W){1'b0}}, hue_half_width_r});
    in_band = div_tag.live && (hue_s >= band_lo) && (hue_s <= band_hi);
  end

  logic            out_valid_r;
  logic [CH_W-1:0] out_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_mask_r <= in_band ? MASK_ON : MASK_OFF;
  end

  assign out_valid      = out_valid_r;
  assign out_mask_value = out_mask_r;

  // checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("mask transaction without a matching pixel transaction");

  a_mask_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mask_value == MASK_ON) || (out_mask_value == MASK_OFF))
    else $error("mask value is neither on nor off");

  a_on_needs_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mask_value == MASK_ON) |-> $past(div_tag.live))
    else $error("dark or grey pixel passed the band");

endmodule

@@ tb/rgbh_mask_checker.sv @@
// checker for the rgb hue band threshold unit: watches the pixel, mask and register channels
// predicts each mask pixel and compares it in order; depends on rgbh_pkg
`timescale 1ns / 1ps

module rgbh_mask_checker
  import rgbh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [CH_W-1:0]      in_red,
  input  logic [CH_W-1:0]      in_green,
  input  logic [CH_W-1:0]      in_blue,
  input  logic                 out_valid,
  input  logic [CH_W-1:0]      out_mask_value,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CH_W-1:0]      cfg_data,
  output int unsigned          fail_count,
  output int unsigned          pending_count
);

  // shadow copy of the unit's registers
  logic [CH_W-1:0] value_thr   = '0;
  logic [CH_W-1:0] band_center = '0;
  logic [CH_W-1:0] band_half   = '0;

  // masks predicted for accepted pixels, oldest first
  logic [CH_W-1:0] expected_masks[$];
  int unsigned     mismatches = 0;

  // mask of one pixel under the current register values
  function automatic logic [CH_W-1:0] mask_of_pixel(input logic [CH_W-1:0] r,
                                                    input logic [CH_W-1:0] g,
                                                    input logic [CH_W-1:0] b);
    int rv, gv, bv, peak, dim, spread, base, num, hue, lo, hi;
    rv = int'(r);
    gv = int'(g);
    bv = int'(b);
    peak = rv;
    if (gv > peak) peak = gv;
    if (bv > peak) peak = bv;
    dim = rv;
    if (gv < dim) dim = gv;
    if (bv < dim) dim = bv;
    spread = peak - dim;
    // dark, below threshold, or grey
    if (peak == 0 || peak < int'(value_thr) || spread == 0) return MASK_OFF;
    // red wins ties, then green
    if (peak == rv) begin
      base = int'(HUE_BASE_RED);
      num  = gv - bv;
    end else if (peak == gv) begin
      base = int'(HUE_BASE_GREEN);
      num  = bv - rv;
    end else begin
      base = int'(HUE_BASE_BLUE);
      num  = rv - gv;
    end
    // signed int division truncates toward zero, hue wraps to 8 bits
    hue = (base + (int'(HUE_SCALE) * num) / spread) & 255;
    // band edges are not wrapped
    lo = int'(band_center) - int'(band_half);
    hi = int'(band_center) + int'(band_half);
    return (hue >= lo && hue <= hi) ? MASK_ON : MASK_OFF;
  endfunction

  task automatic note_mismatch(input string what, input int want, input logic [CH_W-1:0] got);
    if (mismatches < 10) $display("mask check: %s, expected %0d, got %0d", what, want, got);
    mismatches++;
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      value_thr   = '0;
      band_center = '0;
      band_half   = '0;
      expected_masks.delete();
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_VALUE_THRESHOLD: value_thr = cfg_data;
          CFG_HUE_CENTER:      band_center = cfg_data;
          CFG_HUE_HALF_WIDTH:  band_half = cfg_data;
          default: ;
        endcase
      end
      // pixel transaction
      if (start && !busy) expected_masks.push_back(mask_of_pixel(in_red, in_green, in_blue));
      // mask transaction
      if (out_valid) begin
        if (expected_masks.size() == 0) begin
          note_mismatch("mask with no pixel waiting", -1, out_mask_value);
        end else begin
          logic [CH_W-1:0] want;
          want = expected_masks.pop_front();
          if (out_mask_value !== want) begin
            note_mismatch("mask_value differs", int'(want), out_mask_value);
          end
        end
      end
    end
    pending_count <= expected_masks.size();
    fail_count    <= mismatches;
  end

endmodule

@@ tb/tb_rgb_hue_band_threshold_unit.sv @@
// top of the rgb hue band threshold unit testbench: clock, reset, stimulus and verdict
// depends on rgbh_pkg, rgb_hue_band_threshold_unit and rgbh_mask_checker
`timescale 1ns / 1ps

module tb_rgb_hue_band_threshold_unit
  import rgbh_pkg::*;
;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int PHASES         = 8;
  localparam int PHASE_PIXELS   = 150;
  localparam int N_DIRECTED     = 12;
  // index past the last register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CH_W-1:0]      in_red = '0;
  logic [CH_W-1:0]      in_green = '0;
  logic [CH_W-1:0]      in_blue = '0;
  logic                 out_valid;
  logic [CH_W-1:0]      out_mask_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CH_W-1:0]      cfg_data = '0;
  int unsigned          fail_count;
  int unsigned          pending_count;

  logic [3*CH_W-1:0] directed_pixels [0:N_DIRECTED-1];

  always #(CLK_PERIOD / 2) clk = ~clk;

  rgb_hue_band_threshold_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_mask_value(out_mask_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  rgbh_mask_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_mask_value(out_mask_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // one pixel transaction after an optional idle gap; returns just after the accepting edge
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drain the pipeline, then write all registers plus a dropped spare write
  task automatic apply_settings(input logic [CH_W-1:0] thr, input logic [CH_W-1:0] center,
                                input logic [CH_W-1:0] half);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CH_W-1:0]      val [4];
    idx[0] = CFG_VALUE_THRESHOLD;
    val[0] = thr;
    idx[1] = CFG_SPARE_IDX;
    val[1] = CH_W'($urandom_range(0, 255));
    idx[2] = CFG_HUE_CENTER;
    val[2] = center;
    idx[3] = CFG_HUE_HALF_WIDTH;
    val[3] = half;
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    // valid stays high across the back to back writes
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // random pixel, weighted toward ties, grey, small spread and channel extremes
  task automatic pick_pixel(output logic [CH_W-1:0] r, output logic [CH_W-1:0] g,
                            output logic [CH_W-1:0] b);
    int unsigned kind, top_v, low_v, step_max;
    kind = $urandom_range(0, 99);
    r = CH_W'($urandom_range(0, 255));
    g = CH_W'($urandom_range(0, 255));
    b = CH_W'($urandom_range(0, 255));
    if (kind < 15) begin
      // two channels share the maximum
      top_v = $urandom_range(1, 255);
      low_v = $urandom_range(0, top_v - 1);
      case ($urandom_range(0, 2))
        0: begin
          r = CH_W'(top_v); g = CH_W'(top_v); b = CH_W'(low_v);
        end
        1: begin
          r = CH_W'(top_v); b = CH_W'(top_v); g = CH_W'(low_v);
        end
        default: begin
          g = CH_W'(top_v); b = CH_W'(top_v); r = CH_W'(low_v);
        end
      endcase
    end else if (kind < 20) begin
      // grey, black included
      r = CH_W'($urandom_range(0, 255));
      g = r;
      b = r;
    end else if (kind < 32) begin
      // spread of a few codes only
      top_v = $urandom_range(0, 255);
      step_max = (top_v < 3) ? top_v : 3;
      r = CH_W'(top_v - $urandom_range(0, step_max));
      g = CH_W'(top_v - $urandom_range(0, step_max));
      b = CH_W'(top_v - $urandom_range(0, step_max));
    end else if (kind < 42) begin
      // channel extremes
      r = $urandom_range(0, 1) ? CH_W'(255 - $urandom_range(0, 1))
                               : CH_W'($urandom_range(0, 1));
      g = $urandom_range(0, 1) ? CH_W'(255 - $urandom_range(0, 1))
                               : CH_W'($urandom_range(0, 1));
      b = $urandom_range(0, 1) ? CH_W'(255 - $urandom_range(0, 1))
                               : CH_W'($urandom_range(0, 1));
    end
  endtask

  // generous fixed limit on the whole run
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [CH_W-1:0] r, g, b;
    logic [CH_W-1:0] thr, center, half;
    bit              no_gaps;
    int unsigned     gap;

    // black, grey, primaries, max ties, negative hue, truncation, dim pixel, threshold edge
    directed_pixels = '{
      {8'd0,   8'd0,   8'd0},
      {8'd255, 8'd255, 8'd255},
      {8'd255, 8'd0,   8'd0},
      {8'd0,   8'd255, 8'd0},
      {8'd0,   8'd0,   8'd255},
      {8'd255, 8'd255, 8'd0},
      {8'd0,   8'd255, 8'd255},
      {8'd255, 8'd0,   8'd255},
      {8'd200, 8'd50,  8'd100},
      {8'd10,  8'd20,  8'd30},
      {8'd1,   8'd0,   8'd0},
      {8'd200, 8'd200, 8'd0}
    };

    // reset
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a few pixels under reset values
    for (int i = 0; i < 4; i++) begin
      send_pixel(directed_pixels[i][23:16], directed_pixels[i][15:8],
                 directed_pixels[i][7:0], 0);
    end

    // directed: band wider than the hue scale, then a single hue code with high threshold
    apply_settings(8'd0, 8'd128, 8'd255);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pixel(directed_pixels[i][23:16], directed_pixels[i][15:8],
                 directed_pixels[i][7:0], 0);
    end
    apply_settings(8'd200, 8'd43, 8'd0);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pixel(directed_pixels[i][23:16], directed_pixels[i][15:8],
                 directed_pixels[i][7:0], $urandom_range(0, 1));
    end

    // random phases, the first ones at the register extremes
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          thr = 8'd0; center = 8'd0; half = 8'd0;
        end
        1: begin
          thr = 8'd255; center = 8'd255; half = 8'd255;
        end
        2: begin
          thr = 8'd0; center = 8'd255; half = 8'd0;
        end
        3: begin
          thr = 8'd0; center = 8'd0; half = 8'd255;
        end
        default: begin
          thr    = $urandom_range(0, 1) ? CH_W'($urandom_range(0, 255))
                                        : CH_W'($urandom_range(0, 63));
          center = CH_W'($urandom_range(0, 255));
          half   = $urandom_range(0, 1) ? CH_W'($urandom_range(0, 255))
                                        : CH_W'($urandom_range(0, 40));
        end
      endcase
      apply_settings(thr, center, half);
      no_gaps = (p % 3 == 0);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        pick_pixel(r, g, b);
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        send_pixel(r, g, b, gap);
      end
    end

    // drain and verdict
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rgbh_pkg.sv
design/rgbh_divider.sv
design/rgb_hue_band_threshold_unit.sv
tb/rgbh_mask_checker.sv
tb/tb_rgb_hue_band_threshold_unit.sv
